FILE: design/jac_pkg.sv
package jac_pkg;

    localparam int POS_W    = 16;
    localparam int BTN_W    = 9;
    localparam int KEY_W    = 7;
    localparam int MOT_W    = 14;
    localparam int DZ_W     = 13;
    localparam int QUO_W    = 13;
    localparam int NUM_W    = POS_W + QUO_W;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam int FULL_SCALE = 5000;
    localparam int SCALE_BIAS = 4000;

    localparam logic [POS_W-1:0] RANGE_RST = 16'hFFFF;
    localparam logic [DZ_W-1:0]  DZ_RST    = 13'd800;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ROT   = 2'd1,
        MODE_TRANS = 2'd2,
        MODE_SCALE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_X_MIN     = 3'd0,
        REG_X_RANGE   = 3'd1,
        REG_Y_MIN     = 3'd2,
        REG_Y_RANGE   = 3'd3,
        REG_Z_MIN     = 3'd4,
        REG_Z_RANGE   = 3'd5,
        REG_HAS_Z     = 3'd6,
        REG_DEAD_ZONE = 3'd7
    } t_reg_idx;

endpackage

FILE: design/jac_ifs.sv
interface jac_in_if import jac_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             read_ok;
    logic [POS_W-1:0] x_position;
    logic [POS_W-1:0] y_position;
    logic [POS_W-1:0] z_position;
    logic [BTN_W-1:0] button_levels;

    modport source (output valid, read_ok, x_position, y_position, z_position,
                    button_levels, input ready);
    modport sink   (input valid, read_ok, x_position, y_position, z_position,
                    button_levels, output ready);
endinterface

interface jac_out_if import jac_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              move_mode;
    logic signed [MOT_W-1:0] motion_a;
    logic signed [MOT_W-1:0] motion_b;
    logic signed [MOT_W-1:0] motion_c;
    logic [MOT_W-1:0]        scale_units;
    logic                    reset_view;
    logic [KEY_W-1:0]        key_events;

    modport source (output valid, move_mode, motion_a, motion_b, motion_c, scale_units,
                    reset_view, key_events, input ready);
    modport sink   (input valid, move_mode, motion_a, motion_b, motion_c, scale_units,
                    reset_view, key_events, output ready);
endinterface

FILE: design/joystick_axis_conditioner.sv
// Channel    Dir  Handshake      Payload
// i_in       in   valid/ready    read_ok, x/y/z_position, button_levels
// o_out      out  valid/ready    move_mode, motion_a/b/c, scale_units, reset_view, key_events
// APB        in   psel/penable   paddr, pwdata, prdata (eight registers at 4*i)
//
// A good sample runs through the same steps for each of the three axes in turn (clamp,
// span, multiply, 13 divider steps, dead zone) on one shared restoring divider, then the
// emit state loads the output register once it is free; only then is a new sample taken.
// A failed read is accepted and produces no beat.
// Reset is synchronous and active low; it restores the register defaults, the mode and
// the button history. A stalled output beat holds in its register while the next sample
// is taken and worked on.
module joystick_axis_conditioner import jac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jac_in_if.sink            i_in,
    jac_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLAMP, ST_SPAN, ST_MUL, ST_DIV, ST_DZONE, ST_EMIT
    } t_state;

    typedef enum logic [1:0] {AXIS_X = 2'd0, AXIS_Y = 2'd1, AXIS_Z = 2'd2} t_axis;

    // Configuration registers.
    logic [POS_W-1:0] r_x_min, r_x_range, r_y_min, r_y_range, r_z_min, r_z_range;
    logic             r_has_z;
    logic [DZ_W-1:0]  r_dead_zone;

    // Control state.
    t_state           r_state;
    t_axis            r_axis;
    logic [3:0]       r_cnt;
    t_mode            r_mode;
    logic [BTN_W-1:0] r_prev;
    logic             r_out_valid;

    // Datapath.
    logic [POS_W-1:0]        r_pos [3];
    logic signed [MOT_W-1:0] r_val [3];
    logic [POS_W-1:0]        r_d;
    logic [POS_W-1:0]        r_mag;
    logic                    r_neg;
    logic [POS_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_shq;
    logic                    r_reset_view;
    logic [KEY_W-1:0]        r_keys;

    // Output register.
    t_mode                   r_out_mode;
    logic signed [MOT_W-1:0] r_out_a, r_out_b, r_out_c;
    logic [MOT_W-1:0]        r_out_s;
    logic                    r_out_reset_view;
    logic [KEY_W-1:0]        r_out_keys;

    logic                    cfg_wr;
    t_reg_idx                cfg_idx;
    logic [BTN_W-1:0]        n_rising;
    t_mode                   n_mode;
    logic [POS_W-1:0]        cur_pos, cur_min, cur_range;
    logic [POS_W:0]          diff;
    logic [POS_W-1:0]        clamped;
    logic [POS_W:0]          span;
    logic [POS_W:0]          span_neg;
    logic [NUM_W-1:0]        prod;
    logic [POS_W:0]          trial;
    logic                    trial_ge;
    logic [QUO_W-1:0]        quo;
    logic [DZ_W-1:0]         dz_mag;
    logic signed [MOT_W-1:0] n_val;
    logic signed [MOT_W:0]   scale_sum;
    logic signed [MOT_W-1:0] n_a, n_b, n_c;
    logic [MOT_W-1:0]        n_s;
    logic                    out_free;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min     <= '0;
            r_x_range   <= RANGE_RST;
            r_y_min     <= '0;
            r_y_range   <= RANGE_RST;
            r_z_min     <= '0;
            r_z_range   <= RANGE_RST;
            r_has_z     <= 1'b0;
            r_dead_zone <= DZ_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_X_MIN:     r_x_min     <= pwdata[POS_W-1:0];
                REG_X_RANGE:   r_x_range   <= pwdata[POS_W-1:0];
                REG_Y_MIN:     r_y_min     <= pwdata[POS_W-1:0];
                REG_Y_RANGE:   r_y_range   <= pwdata[POS_W-1:0];
                REG_Z_MIN:     r_z_min     <= pwdata[POS_W-1:0];
                REG_Z_RANGE:   r_z_range   <= pwdata[POS_W-1:0];
                REG_HAS_Z:     r_has_z     <= pwdata[0];
                REG_DEAD_ZONE: r_dead_zone <= pwdata[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_X_MIN:     prdata = APB_DW'(r_x_min);
            REG_X_RANGE:   prdata = APB_DW'(r_x_range);
            REG_Y_MIN:     prdata = APB_DW'(r_y_min);
            REG_Y_RANGE:   prdata = APB_DW'(r_y_range);
            REG_Z_MIN:     prdata = APB_DW'(r_z_min);
            REG_Z_RANGE:   prdata = APB_DW'(r_z_range);
            REG_HAS_Z:     prdata = APB_DW'(r_has_z);
            REG_DEAD_ZONE: prdata = APB_DW'(r_dead_zone);
            default:       prdata = '0;
        endcase
    end

    // Button edges and the mode step, formed on the incoming beat.
    assign n_rising = i_in.button_levels & ~r_prev;
    assign n_mode   = t_mode'(r_mode + 2'(n_rising[1]));

    always_comb begin
        unique case (r_axis)
            AXIS_X: begin
                cur_min   = r_x_min;
                cur_range = r_x_range;
            end
            AXIS_Y: begin
                cur_min   = r_y_min;
                cur_range = r_y_range;
            end
            AXIS_Z: begin
                cur_min   = r_z_min;
                cur_range = r_z_range;
            end
            default: begin
                cur_min   = r_x_min;
                cur_range = r_x_range;
            end
        endcase
    end

    assign cur_pos = r_pos[r_axis];

    // Clamp the offset from the low end into 0..range.
    assign diff = {1'b0, cur_pos} - {1'b0, cur_min};
    always_comb begin
        if (diff[POS_W]) begin
            clamped = '0;
        end else if (diff[POS_W-1:0] > cur_range) begin
            clamped = cur_range;
        end else begin
            clamped = diff[POS_W-1:0];
        end
    end

    // The signed span 2d - range never exceeds range in magnitude, so 16 bits hold its magnitude.
    assign span     = {r_d, 1'b0} - {1'b0, cur_range};
    assign span_neg = ~span + (POS_W+1)'(1);
    assign prod     = NUM_W'(r_mag) * NUM_W'(FULL_SCALE);

    // One restoring step: the next numerator bit enters from the top of the quotient
    // register while the quotient bit enters at its bottom.
    assign trial    = {r_rem, r_shq[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, cur_range};

    assign quo    = (cur_range == '0) ? '0 : r_shq;
    assign dz_mag = (quo > r_dead_zone) ? quo - r_dead_zone : '0;
    assign n_val  = r_neg ? -signed'({1'b0, dz_mag}) : signed'({1'b0, dz_mag});

    assign scale_sum = (MOT_W+1)'(SCALE_BIAS) + {r_val[AXIS_X][MOT_W-1], r_val[AXIS_X]};

    always_comb begin
        n_a = '0;
        n_b = '0;
        n_c = '0;
        n_s = '0;
        unique case (r_mode)
            MODE_ROT: begin
                n_a = r_val[AXIS_Y];
                n_b = r_val[AXIS_X];
                n_c = r_has_z ? r_val[AXIS_Z] : '0;
            end
            MODE_TRANS: begin
                n_a = r_val[AXIS_X];
                n_b = r_val[AXIS_Y];
                n_c = r_has_z ? -r_val[AXIS_Z] : '0;
            end
            MODE_SCALE: begin
                n_s = scale_sum[MOT_W] ? '0 : scale_sum[MOT_W-1:0];
            end
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= AXIS_X;
            r_cnt       <= '0;
            r_mode      <= MODE_OFF;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the emit state the output register is reloaded instead.
            if (r_out_valid && o_out.ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && i_in.read_ok) begin
                        r_pos[AXIS_X] <= i_in.x_position;
                        r_pos[AXIS_Y] <= i_in.y_position;
                        r_pos[AXIS_Z] <= i_in.z_position;
                        r_prev        <= i_in.button_levels;
                        r_mode        <= n_mode;
                        r_reset_view  <= n_rising[0];
                        r_keys        <= n_rising[BTN_W-1:2];
                        r_axis        <= AXIS_X;
                        r_state       <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    r_d     <= clamped;
                    r_state <= ST_SPAN;
                end
                ST_SPAN: begin
                    r_neg   <= span[POS_W];
                    r_mag   <= span[POS_W] ? span_neg[POS_W-1:0] : span[POS_W-1:0];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_rem   <= prod[NUM_W-1:QUO_W];
                    r_shq   <= prod[QUO_W-1:0];
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= trial_ge ? POS_W'(trial - {1'b0, cur_range})
                                      : trial[POS_W-1:0];
                    r_shq <= {r_shq[QUO_W-2:0], trial_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(QUO_W - 1)) begin
                        r_state <= ST_DZONE;
                    end
                end
                ST_DZONE: begin
                    r_val[r_axis] <= n_val;
                    if (r_axis == AXIS_Z) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_axis  <= t_axis'(r_axis + 2'd1);
                        r_state <= ST_CLAMP;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_mode       <= r_mode;
                        r_out_a          <= n_a;
                        r_out_b          <= n_b;
                        r_out_c          <= n_c;
                        r_out_s          <= n_s;
                        r_out_reset_view <= r_reset_view;
                        r_out_keys       <= r_keys;
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.move_mode   = r_out_mode;
    assign o_out.motion_a    = r_out_a;
    assign o_out.motion_b    = r_out_b;
    assign o_out.motion_c    = r_out_c;
    assign o_out.scale_units = r_out_s;
    assign o_out.reset_view  = r_out_reset_view;
    assign o_out.key_events  = r_out_keys;

    // The partial remainder always stays below the divisor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && cur_range != '0) |-> (r_rem < cur_range))
        else $error("divider remainder not below divisor");

    // A failed read leaves the mode alone and produces no work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.read_ok) |=> (r_state == ST_IDLE && $stable(r_mode)))
        else $error("failed read disturbed state");

    // Only scaling mode carries a scale value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.move_mode != MODE_SCALE) |-> (o_out.scale_units == '0))
        else $error("scale value outside scaling mode");

    // Off and scaling modes carry no motion.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.move_mode == MODE_OFF || o_out.move_mode == MODE_SCALE))
        |-> (o_out.motion_a == '0 && o_out.motion_b == '0 && o_out.motion_c == '0))
        else $error("motion value in a mode without motion");

endmodule

FILE: verif/jac_checker.sv
`timescale 1ns / 1ps

module jac_checker import jac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jac_in_if                 i_sample,
    jac_out_if                i_report,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        t_mode                   mode;
        logic signed [MOT_W-1:0] motion_a;
        logic signed [MOT_W-1:0] motion_b;
        logic signed [MOT_W-1:0] motion_c;
        logic [MOT_W-1:0]        scale_units;
        logic                    reset_view;
        logic [KEY_W-1:0]        key_events;
    } motion_report_t;

    motion_report_t   expected_reports[$];
    int               fail_total = 0;

    logic [POS_W-1:0] x_min_q, x_range_q, y_min_q, y_range_q, z_min_q, z_range_q;
    logic             has_z_q;
    logic [DZ_W-1:0]  dead_zone_q;
    logic [BTN_W-1:0] last_buttons;
    t_mode            motion_mode;

    assign o_fail_count = fail_total;
    assign o_pending    = expected_reports.size();

    // Maps a raw reading onto -5000..5000 across the travel, truncating towards
    // zero, and then pulls it towards zero by the dead zone.
    function automatic int conditioned_axis(input logic [POS_W-1:0] pos,
                                            input logic [POS_W-1:0] lo,
                                            input logic [POS_W-1:0] span,
                                            input logic [DZ_W-1:0]  dz);
        longint d, sp, num;
        int     v, z;
        if (span == '0) begin
            return 0;
        end
        d  = longint'(pos);
        sp = longint'(span);
        d  = d - longint'(lo);
        if (d < 0) begin
            d = 0;
        end
        if (d > sp) begin
            d = sp;
        end
        num = FULL_SCALE * (2 * d - sp);
        v   = int'(num / sp);
        z   = int'(dz);
        if (v > z) begin
            return v - z;
        end
        if (v < -z) begin
            return v + z;
        end
        return 0;
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        logic [BTN_W-1:0] rising;
        int               vx, vy, vz, sc;
        motion_report_t   want;
        if (!i_rst_n) begin
            x_min_q     <= '0;
            x_range_q   <= RANGE_RST;
            y_min_q     <= '0;
            y_range_q   <= RANGE_RST;
            z_min_q     <= '0;
            z_range_q   <= RANGE_RST;
            has_z_q     <= 1'b0;
            dead_zone_q <= DZ_RST;
            last_buttons = '0;
            motion_mode  = MODE_OFF;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_X_MIN:     x_min_q     <= pwdata[POS_W-1:0];
                    REG_X_RANGE:   x_range_q   <= pwdata[POS_W-1:0];
                    REG_Y_MIN:     y_min_q     <= pwdata[POS_W-1:0];
                    REG_Y_RANGE:   y_range_q   <= pwdata[POS_W-1:0];
                    REG_Z_MIN:     z_min_q     <= pwdata[POS_W-1:0];
                    REG_Z_RANGE:   z_range_q   <= pwdata[POS_W-1:0];
                    REG_HAS_Z:     has_z_q     <= pwdata[0];
                    REG_DEAD_ZONE: dead_zone_q <= pwdata[DZ_W-1:0];
                    default: ;
                endcase
            end

            // The output beat at an edge can never belong to a sample taken at the
            // same edge, so it is matched before that sample is predicted.
            if (i_report.valid && i_report.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result beat with no sample awaiting it", $time);
                    fail_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("move_mode",   32'(want.mode),        32'(i_report.move_mode));
                    check_field("motion_a",    32'(want.motion_a),    32'(i_report.motion_a));
                    check_field("motion_b",    32'(want.motion_b),    32'(i_report.motion_b));
                    check_field("motion_c",    32'(want.motion_c),    32'(i_report.motion_c));
                    check_field("scale_units", 32'(want.scale_units),
                                32'(i_report.scale_units));
                    check_field("reset_view",  32'(want.reset_view),
                                32'(i_report.reset_view));
                    check_field("key_events",  32'(want.key_events),
                                32'(i_report.key_events));
                end
            end

            // A failed read yields nothing and leaves the button history alone.
            if (i_sample.valid && i_sample.ready && i_sample.read_ok) begin
                vx = conditioned_axis(i_sample.x_position, x_min_q, x_range_q, dead_zone_q);
                vy = conditioned_axis(i_sample.y_position, y_min_q, y_range_q, dead_zone_q);
                vz = conditioned_axis(i_sample.z_position, z_min_q, z_range_q, dead_zone_q);
                rising = i_sample.button_levels & ~last_buttons;
                if (rising[1]) begin
                    motion_mode = t_mode'(motion_mode + 2'd1);
                end
                want.mode        = motion_mode;
                want.motion_a    = '0;
                want.motion_b    = '0;
                want.motion_c    = '0;
                want.scale_units = '0;
                case (motion_mode)
                    MODE_ROT: begin
                        want.motion_a = MOT_W'(vy);
                        want.motion_b = MOT_W'(vx);
                        want.motion_c = has_z_q ? MOT_W'(vz) : '0;
                    end
                    MODE_TRANS: begin
                        want.motion_a = MOT_W'(vx);
                        want.motion_b = MOT_W'(vy);
                        want.motion_c = has_z_q ? MOT_W'(-vz) : '0;
                    end
                    MODE_SCALE: begin
                        sc = SCALE_BIAS + vx;
                        want.scale_units = (sc < 0) ? '0 : MOT_W'(sc);
                    end
                    default: ;
                endcase
                want.reset_view = rising[0];
                want.key_events = rising[BTN_W-1:2];
                expected_reports.push_back(want);
                last_buttons = i_sample.button_levels;
            end
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jac_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                send_idle_pct, recv_idle_pct;
    int                fail_count, pending;
    logic [POS_W-1:0]  cfg_min [3];
    logic [POS_W-1:0]  cfg_range [3];
    logic [BTN_W-1:0]  held_buttons;

    jac_in_if  sample_if ();
    jac_out_if report_if ();

    always #1 clk = ~clk;

    joystick_axis_conditioner i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_if.sink),
        .o_out   (report_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    jac_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_sample     (sample_if),
        .i_report     (report_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        report_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // psel is left high between writes; the caller drops it after the last one.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic load_config(input logic [POS_W-1:0] xm, input logic [POS_W-1:0] xr,
                               input logic [POS_W-1:0] ym, input logic [POS_W-1:0] yr,
                               input logic [POS_W-1:0] zm, input logic [POS_W-1:0] zr,
                               input logic hz, input logic [DZ_W-1:0] dz);
        write_reg(REG_X_MIN, APB_DW'(xm));
        write_reg(REG_X_RANGE, APB_DW'(xr));
        write_reg(REG_Y_MIN, APB_DW'(ym));
        write_reg(REG_Y_RANGE, APB_DW'(yr));
        write_reg(REG_Z_MIN, APB_DW'(zm));
        write_reg(REG_Z_RANGE, APB_DW'(zr));
        write_reg(REG_HAS_Z, APB_DW'(hz));
        write_reg(REG_DEAD_ZONE, APB_DW'(dz));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_min   = '{xm, ym, zm};
        cfg_range = '{xr, yr, zr};
    endtask

    // valid stays high from one beat to the next unless a gap is chosen.
    task automatic send_sample(input logic ok, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                               input logic [BTN_W-1:0] btn);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.read_ok       <= ok;
        sample_if.x_position    <= x;
        sample_if.y_position    <= y;
        sample_if.z_position    <= z;
        sample_if.button_levels <= btn;
        do @(posedge clk); while (!sample_if.ready);
    endtask

    // A failed read leaves nothing to wait for, so a margin beyond the sample
    // latency follows the last result.
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            4:       return POS_W'($urandom_range(255));
            5:       return POS_W'($urandom_range(40000, 1000));
            default: return POS_W'($urandom_range(65535));
        endcase
    endfunction

    // Half of the readings fall inside the configured travel or close to its centre, where
    // the dead zone bites; the rest are any word, or all zeros or all ones.
    function automatic logic [POS_W-1:0] pick_position(input int axis);
        case ($urandom_range(3))
            0: return POS_W'($urandom_range(65535));
            1: return POS_W'(cfg_min[axis] + $urandom_range(cfg_range[axis]));
            2: return POS_W'(cfg_min[axis] + cfg_range[axis] / 2 + $urandom_range(2000) - 1000);
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    initial begin
        int              r;
        logic [DZ_W-1:0] dz;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        sample_if.valid         = 1'b0;
        sample_if.read_ok       = 1'b0;
        sample_if.x_position    = '0;
        sample_if.y_position    = '0;
        sample_if.z_position    = '0;
        sample_if.button_levels = '0;
        report_if.ready         = 1'b0;
        send_idle_pct           = 31;
        recv_idle_pct           = 75;
        held_buttons            = '0;
        cfg_min                 = '{default: '0};
        cfg_range               = '{default: RANGE_RST};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clamping at both ends of travel, a zero z span, no dead zone, and a
        // full walk through the modes with every button edge.
        load_config(16'd1000, 16'd60000, 16'd0, 16'hFFFF, 16'd30000, 16'd0, 1'b1, 13'd0);
        send_sample(1'b1, 16'd0, 16'd0, 16'd0, 9'h000);
        send_sample(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 9'h002);
        send_sample(1'b1, 16'd500, 16'hFFFF, 16'd0, 9'h000);
        send_sample(1'b1, 16'd31000, 16'd32768, 16'd12345, 9'h002);
        send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF);
        send_sample(1'b1, 16'd0, 16'hFFFF, 16'd0, 9'h000);
        send_sample(1'b1, 16'd0, 16'd0, 16'd0, 9'h002);
        send_sample(1'b1, 16'hFFFF, 16'd0, 16'd0, 9'h000);
        send_sample(1'b1, 16'd45000, 16'd0, 16'd0, 9'h1FF);
        send_sample(1'b1, 16'd45000, 16'd0, 16'd0, 9'h1FF);
        send_sample(1'b1, 16'd0, 16'd0, 16'd0, 9'h001);
        send_sample(1'b1, 16'd0, 16'd0, 16'd0, 9'h154);
        wait_idle();

        // Values right at the dead zone edge, and no z axis.
        load_config(16'd0, 16'd10000, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 13'd800);
        send_sample(1'b1, 16'd5800, 16'd0, 16'hFFFF, 9'h002);
        send_sample(1'b1, 16'd5802, 16'hFFFF, 16'd0, 9'h000);
        send_sample(1'b1, 16'd4198, 16'd100, 16'd0, 9'h002);
        send_sample(1'b1, 16'd4199, 16'd0, 16'hFFFF, 9'h000);
        wait_idle();

        // A dead zone wider than full scale, a unit span and a zero span.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 1'b1, 13'h1FFF);
        send_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h002);
        send_sample(1'b1, 16'd0, 16'd0, 16'd0, 9'h000);
        send_sample(1'b1, 16'd0, 16'hFFFF, 16'd0, 9'h002);
        send_sample(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 9'h000);
        send_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h002);

        for (int seg = 0; seg < 6; seg++) begin
            wait_idle();
            case (seg / 2)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case ($urandom_range(4))
                0:       dz = '0;
                1:       dz = 13'd5000;
                2:       dz = '1;
                default: dz = DZ_W'($urandom_range(2000));
            endcase
            if (seg == 0) begin
                load_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, DZ_RST);
            end else begin
                load_config(pick_word(), pick_word(), pick_word(), pick_word(),
                            pick_word(), pick_word(), 1'($urandom_range(1)), dz);
            end
            for (int i = 0; i < 213; i++) begin
                r = $urandom_range(9);
                if (r < BTN_W) begin
                    held_buttons[r] = ~held_buttons[r];
                end else begin
                    held_buttons = BTN_W'($urandom_range(511));
                end
                send_sample($urandom_range(9) != 0, pick_position(0), pick_position(1),
                            pick_position(2), held_buttons);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
